// ===== sv/gn2d_pkg.sv =====
`default_nettype none
package gn2d_pkg;

  localparam int GRID_MAX    = 63;
  localparam int SIDE_BITS   = 6;
  localparam int TABLE_DEPTH = 1 << (2 * SIDE_BITS);
  localparam int ADDR_BITS   = 2 * SIDE_BITS;
  localparam int GRAD_LIMIT  = 16384;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  localparam logic REG_GRID_COLUMNS = 1'b0;
  localparam logic REG_GRID_ROWS    = 1'b1;

  typedef struct packed {
    logic               command;
    logic [5:0]         entry_row;
    logic [5:0]         entry_column;
    logic signed [15:0] gradient_dx;
    logic signed [15:0] gradient_dy;
    logic [16:0]        point_x;
    logic [16:0]        point_y;
  } in_beat_t;

  typedef struct packed {
    logic signed [15:0] noise_value;
    logic               outside_grid;
  } out_beat_t;

  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
  } grad_t;

  typedef struct packed {
    logic        valid;
    logic        outside;
    logic [15:0] fx;
    logic [15:0] fy;
  } stage_ctl_t;

endpackage
`default_nettype wire

// ===== sv/gradient_noise_2d_top.sv =====
`default_nettype none
// Two-dimensional gradient noise with bilinear blending of the four corner
// dot products. The input channel (in_valid, in_stall, in_data) carries two
// kinds of beat: a load beat writes one gradient pair into the lattice
// table, and an evaluate beat asks for the noise value at a point of the
// unit square. Only evaluate beats produce an output beat (out_valid,
// out_stall, out_data); loads are absorbed.
// The grid size is set through cfg_write, cfg_index and cfg_data: index 0
// sets the number of columns, index 1 the rows. The user must set it only
// while the block is idle; the block does not enforce this. Throughput is
// one beat per clock unless the receiver stalls. Scaling, the table read, the
// dot products and the horizontal and vertical blends each take one register stage.
// The table is held in four copies of one memory so that all four corners
// are read in the same cycle; each load writes every copy.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall is raised, so nothing is lost or repeated.
// Reset clears the valid bits and sets both grid sizes to 16. The gradient
// table is not cleared; software must load every entry it will use.
module gradient_noise_2d_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire gn2d_pkg::in_beat_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output gn2d_pkg::out_beat_t      out_data,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [5:0]          cfg_data
);
  import gn2d_pkg::*;

  logic       en;
  logic [5:0] grid_columns;
  logic [5:0] grid_rows;
  logic [5:0] cfg_value;
  stage_ctl_t ctl2, ctl3;
  grad_t      grad2 [4];
  logic signed [17:0] dot3 [4];

  // The pipeline moves unless a finished result is being held back.
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  assign cfg_value = ({2'b00, cfg_data} > 8'(GRID_MAX)) ? 6'(GRID_MAX) : cfg_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= 6'd16;
      grid_rows    <= 6'd16;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_GRID_COLUMNS: grid_columns <= cfg_value;
        REG_GRID_ROWS:    grid_rows    <= cfg_value;
        default:          grid_rows    <= grid_rows;
      endcase
    end
  end

  gn2d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (in_valid),
    .in_data     (in_data),
    .grid_columns(grid_columns),
    .grid_rows   (grid_rows),
    .ctl_out     (ctl2),
    .grad_out    (grad2)
  );

  gn2d_dot u_dot (
    .clk    (clk),
    .rst    (rst),
    .en     (en),
    .ctl_in (ctl2),
    .grad_in(grad2),
    .ctl_out(ctl3),
    .dot    (dot3)
  );

  gn2d_blend u_blend (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .ctl_in   (ctl3),
    .dot      (dot3),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ===== sv/gn2d_ram.sv =====
`default_nettype none
module gn2d_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read-first: a read and a write to the same entry return the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== sv/gn2d_front.sv =====
`default_nettype none
module gn2d_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire logic                  in_valid,
  input  wire gn2d_pkg::in_beat_t    in_data,
  input  wire logic [5:0]            grid_columns,
  input  wire logic [5:0]            grid_rows,
  output gn2d_pkg::stage_ctl_t       ctl_out,
  output gn2d_pkg::grad_t            grad_out [4]
);
  import gn2d_pkg::*;

  logic        v1;
  logic [22:0] sx;
  logic [22:0] sy;
  logic        load_we;
  logic [ADDR_BITS-1:0] load_addr;
  grad_t       load_word;
  logic [6:0]  x0;
  logic [6:0]  y0;
  logic [5:0]  col0, col1, row0, row1;
  logic [ADDR_BITS-1:0] raddr [4];

  function automatic logic signed [15:0] clamp_grad(input logic signed [15:0] v);
    logic signed [15:0] r;
    r = v;
    if (v > 16'(GRAD_LIMIT)) r = 16'(GRAD_LIMIT);
    if (v < -16'(GRAD_LIMIT)) r = -16'(GRAD_LIMIT);
    return r;
  endfunction

  assign load_we      = in_valid && en && (in_data.command == CMD_LOAD);
  assign load_addr    = {in_data.entry_row, in_data.entry_column};
  assign load_word.gx = clamp_grad(in_data.gradient_dx);
  assign load_word.gy = clamp_grad(in_data.gradient_dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid && (in_data.command == CMD_EVAL);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sx <= in_data.point_x * grid_columns;
      sy <= in_data.point_y * grid_rows;
    end
  end

  assign x0   = sx[22:16];
  assign y0   = sy[22:16];
  assign col0 = x0[5:0];
  assign col1 = x0[5:0] + 6'd1;
  assign row0 = y0[5:0];
  assign row1 = y0[5:0] + 6'd1;

  assign raddr[0] = {row0, col0};
  assign raddr[1] = {row0, col1};
  assign raddr[2] = {row1, col0};
  assign raddr[3] = {row1, col1};

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= v1;
    end
    if (en) begin
      ctl_out.outside <= (x0 >= {1'b0, grid_columns}) || (y0 >= {1'b0, grid_rows});
      ctl_out.fx      <= sx[15:0];
      ctl_out.fy      <= sy[15:0];
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_copy
    gn2d_ram #(
      .WIDTH($bits(grad_t)),
      .DEPTH(TABLE_DEPTH)
    ) u_ram (
      .clk  (clk),
      .we   (load_we),
      .waddr(load_addr),
      .wdata(load_word),
      .re   (en),
      .raddr(raddr[c]),
      .rdata(grad_out[c])
    );
  end

endmodule
`default_nettype wire

// ===== sv/gn2d_dot.sv =====
`default_nettype none
module gn2d_dot (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire gn2d_pkg::stage_ctl_t  ctl_in,
  input  wire gn2d_pkg::grad_t       grad_in [4],
  output gn2d_pkg::stage_ctl_t       ctl_out,
  output logic signed [17:0]         dot [4]
);
  import gn2d_pkg::*;

  logic signed [16:0] ox [4];
  logic signed [16:0] oy [4];
  logic signed [33:0] sum [4];

  // Offset from the far corner is fraction minus one, which is {1, fraction}.
  assign ox[0] = {1'b0, ctl_in.fx};
  assign ox[1] = {1'b1, ctl_in.fx};
  assign ox[2] = {1'b0, ctl_in.fx};
  assign ox[3] = {1'b1, ctl_in.fx};
  assign oy[0] = {1'b0, ctl_in.fy};
  assign oy[1] = {1'b0, ctl_in.fy};
  assign oy[2] = {1'b1, ctl_in.fy};
  assign oy[3] = {1'b1, ctl_in.fy};

  for (genvar c = 0; c < 4; c++) begin : g_corner
    assign sum[c] = 34'(ox[c] * grad_in[c].gx) + 34'(oy[c] * grad_in[c].gy);
    always_ff @(posedge clk) begin
      if (en) begin
        dot[c] <= sum[c][33:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else if (en) begin
      ctl_out.valid <= ctl_in.valid;
    end
    if (en) begin
      ctl_out.outside <= ctl_in.outside;
      ctl_out.fx      <= ctl_in.fx;
      ctl_out.fy      <= ctl_in.fy;
    end
  end

endmodule
`default_nettype wire

// ===== sv/gn2d_blend.sv =====
`default_nettype none
module gn2d_blend (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire gn2d_pkg::stage_ctl_t  ctl_in,
  input  wire logic signed [17:0]    dot [4],
  output logic                       out_valid,
  output gn2d_pkg::out_beat_t        out_data
);
  import gn2d_pkg::*;

  logic signed [17:0] wx, wx_c, wy, wy_c;
  logic signed [36:0] top_sum, bot_sum, fin_sum;
  logic               v4;
  logic               outside4;
  logic [15:0]        fy4;
  logic signed [17:0] top, bottom;
  logic signed [20:0] v;
  logic signed [15:0] sat;

  assign wx      = {2'b00, ctl_in.fx};
  assign wx_c    = 18'sd65536 - wx;
  assign top_sum = 37'(wx_c * dot[0]) + 37'(wx * dot[1]);
  assign bot_sum = 37'(wx_c * dot[2]) + 37'(wx * dot[3]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= ctl_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top      <= top_sum[33:16];
      bottom   <= bot_sum[33:16];
      outside4 <= ctl_in.outside;
      fy4      <= ctl_in.fy;
    end
  end

  assign wy      = {2'b00, fy4};
  assign wy_c    = 18'sd65536 - wy;
  assign fin_sum = 37'(wy_c * top) + 37'(wy * bottom);
  assign v       = fin_sum[36:16];

  always_comb begin
    if (v > 21'sd32767) begin
      sat = 16'sh7fff;
    end else if (v < -21'sd32768) begin
      sat = 16'sh8000;
    end else begin
      sat = v[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.noise_value  <= outside4 ? 16'sd0 : sat;
      out_data.outside_grid <= outside4;
    end
  end

endmodule
`default_nettype wire
